/* sv/vdft_pkg.sv */
// ----------------------------------------------------------------------------
// vdft_pkg
// Shared constants and types for the vertex dedup fan triangulator.
// ----------------------------------------------------------------------------
package vdft_pkg;

	localparam int TABLE_DEPTH_DEF      = 256;
	localparam int MAX_FACE_CORNERS_DEF = 64;
	localparam int INDEX_BITS_DEF       = 20;

	// vertex indices leave the block modulo 256
	localparam int VTX_BITS          = 8;
	localparam int MIN_FACE_CORNERS  = 3;
	localparam int TRI_START_CORNER  = 2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} vdft_state_t;

endpackage

/* sv/vertex_dedup_fan_triangulator.sv */
// ----------------------------------------------------------------------------
// vertex_dedup_fan_triangulator
// Corner stream to unique vertex indices and fan triangles.
// ----------------------------------------------------------------------------
// One input item is one polygon corner (position, normal, texture index, face
// end flag, mesh start flag). One output item follows for every input item:
// the corner's unique vertex index, a new-vertex flag, the fan triangle from
// the third corner of a face onward, and table full, short face and dropped
// corner flags. Both channels use valid/ready.
// The key table is a single-port memory scanned in insertion order, one entry
// a cycle through one shared key comparator. The search ends on the first hit
// or after all stored entries on a miss; a dropped corner skips the search.
// One corner is in work at a time; in_ready is high only while the sequencer
// is idle.
// A finished result waits in the output register; while out_valid is high and
// out_ready low the next corner may still be accepted and searched, and it is
// committed once the output register frees.
// Reset empties the table and the face state at once; no clearing pass.
// ----------------------------------------------------------------------------
module vertex_dedup_fan_triangulator #(
	parameter int TABLE_DEPTH      = vdft_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_FACE_CORNERS = vdft_pkg::MAX_FACE_CORNERS_DEF,
	parameter int INDEX_BITS       = vdft_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [INDEX_BITS-1:0]         position_index,
	input  logic [INDEX_BITS-1:0]         normal_index,
	input  logic signed [INDEX_BITS:0]    texture_index,
	input  logic                          last_corner,
	input  logic                          start_mesh,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vdft_pkg::VTX_BITS-1:0] vertex_index,
	output logic                          vertex_is_new,
	output logic                          triangle_valid,
	output logic [vdft_pkg::VTX_BITS-1:0] triangle_first,
	output logic [vdft_pkg::VTX_BITS-1:0] triangle_second,
	output logic [vdft_pkg::VTX_BITS-1:0] triangle_third,
	output logic                          table_full,
	output logic                          face_too_short,
	output logic                          corner_dropped
);
	import vdft_pkg::*;

	localparam int KW  = 3 * INDEX_BITS + 1;
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int CCW = $clog2(MAX_FACE_CORNERS + 1);

	vdft_state_t state_q;

	logic [KW-1:0]       key_mem [TABLE_DEPTH];
	logic [KW-1:0]       key_q;
	logic [KW-1:0]       rd_data_s1;
	logic [AW-1:0]       rd_addr_s1;
	logic                rd_vld_s1;
	logic [CW-1:0]       addr_q;
	logic [CW-1:0]       entry_count_q;
	logic [CCW-1:0]      corner_count_q;
	logic [VTX_BITS-1:0] first_q;
	logic [VTX_BITS-1:0] prev_q;
	logic [AW-1:0]       idx_q;
	logic                found_q;
	logic                dropped_q;
	logic                last_q;

	logic                out_valid_q;
	logic [VTX_BITS-1:0] vidx_q;
	logic                new_q;
	logic                tri_q;
	logic [VTX_BITS-1:0] t0_q;
	logic [VTX_BITS-1:0] t1_q;
	logic [VTX_BITS-1:0] t2_q;
	logic                full_q;
	logic                short_q;
	logic                drop_out_q;

	logic                in_go;
	logic                hit;
	logic                rd_en;
	logic                fin_go;
	logic                tab_full;
	logic                add_new;
	logic [AW-1:0]       idx_c;
	logic [VTX_BITS-1:0] vtx_c;
	logic [CCW-1:0]      cc_eff;
	logic [CCW-1:0]      cc_inc;
	logic                tri_c;
	logic                short_c;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		in_go    = in_valid && in_ready;
		cc_eff   = start_mesh ? '0 : corner_count_q;
		hit      = rd_vld_s1 && (rd_data_s1 == key_q);
		rd_en    = (state_q == ST_SCAN) && (addr_q != entry_count_q) && !hit;
		fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
		tab_full = (entry_count_q == CW'(TABLE_DEPTH));
		add_new  = !dropped_q && !found_q && !tab_full;
		if (dropped_q || (!found_q && tab_full)) begin
			idx_c = '0;
		end else if (found_q) begin
			idx_c = idx_q;
		end else begin
			idx_c = entry_count_q[AW-1:0];
		end
		vtx_c   = VTX_BITS'(idx_c);
		cc_inc  = dropped_q ? corner_count_q : corner_count_q + CCW'(1);
		tri_c   = !dropped_q && (corner_count_q >= CCW'(TRI_START_CORNER));
		short_c = last_q && (cc_inc < CCW'(MIN_FACE_CORNERS));
	end

	// key memory, read port registered
	always_ff @(posedge clk) begin
		if (in_go) begin
			key_q <= {position_index, normal_index, texture_index};
		end
		if (rd_en) begin
			rd_data_s1 <= key_mem[addr_q[AW-1:0]];
			rd_addr_s1 <= addr_q[AW-1:0];
		end
		if (fin_go && add_new) begin
			key_mem[entry_count_q[AW-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_vld_s1      <= 1'b0;
			addr_q         <= '0;
			entry_count_q  <= '0;
			corner_count_q <= '0;
			first_q        <= '0;
			prev_q         <= '0;
			idx_q          <= '0;
			found_q        <= 1'b0;
			dropped_q      <= 1'b0;
			last_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			vidx_q         <= '0;
			new_q          <= 1'b0;
			tri_q          <= 1'b0;
			t0_q           <= '0;
			t1_q           <= '0;
			t2_q           <= '0;
			full_q         <= 1'b0;
			short_q        <= 1'b0;
			drop_out_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						last_q    <= last_corner;
						found_q   <= 1'b0;
						addr_q    <= '0;
						dropped_q <= (cc_eff >= CCW'(MAX_FACE_CORNERS));
						if (start_mesh) begin
							entry_count_q  <= '0;
							corner_count_q <= '0;
							first_q        <= '0;
							prev_q         <= '0;
						end
						state_q <= (cc_eff >= CCW'(MAX_FACE_CORNERS)) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + CW'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
						idx_q   <= rd_addr_s1;
						state_q <= ST_FIN;
					end else if (!rd_vld_s1 && (addr_q == entry_count_q)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						if (add_new) begin
							entry_count_q <= entry_count_q + CW'(1);
						end
						if (!dropped_q) begin
							if (corner_count_q == '0) begin
								first_q <= vtx_c;
							end
							prev_q <= vtx_c;
						end
						corner_count_q <= last_q ? '0 : cc_inc;
						out_valid_q    <= 1'b1;
						vidx_q         <= vtx_c;
						new_q          <= add_new;
						tri_q          <= tri_c;
						t0_q           <= tri_c ? first_q : '0;
						t1_q           <= tri_c ? prev_q : '0;
						t2_q           <= tri_c ? vtx_c : '0;
						full_q         <= !dropped_q && !found_q && tab_full;
						short_q        <= short_c;
						drop_out_q     <= dropped_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign vertex_index    = vidx_q;
	assign vertex_is_new   = new_q;
	assign triangle_valid  = tri_q;
	assign triangle_first  = t0_q;
	assign triangle_second = t1_q;
	assign triangle_third  = t2_q;
	assign table_full      = full_q;
	assign face_too_short  = short_q;
	assign corner_dropped  = drop_out_q;

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_corner_bound: assert property (@(posedge clk) disable iff (!arst_n)
		corner_count_q <= CCW'(MAX_FACE_CORNERS))
		else $error("corner count beyond face limit");

	a_new_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && new_q |-> !full_q && !drop_out_q)
		else $error("new vertex flagged with full table or dropped corner");

	a_drop_no_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && drop_out_q |-> !tri_q && (vidx_q == '0))
		else $error("dropped corner carries a triangle or index");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> addr_q < entry_count_q)
		else $error("read of an unwritten table entry");

endmodule

/* sim/vertex_dedup_fan_triangulator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_fan_triangulator_test
// Self-checking bench for the vertex dedup fan triangulator.
// ----------------------------------------------------------------------------
// Corners are pushed through the valid/ready input in bursts with random gaps
// while the output side stalls on its own random pattern. Every accepted
// corner runs through a behavioral model of the vertex table and the fan
// state, and each result item is checked field by field against the oldest
// prediction. Directed tests cover field extremes, short faces, mesh restarts,
// the per-face corner limit, a full vertex table and a long output hold-off;
// a random mix of meshes and faces follows.
// ----------------------------------------------------------------------------
module vertex_dedup_fan_triangulator_test;

	import vdft_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int IB             = INDEX_BITS_DEF;
	localparam int DEPTH          = TABLE_DEPTH_DEF;
	localparam int FACE_LIMIT     = MAX_FACE_CORNERS_DEF;
	localparam int RANDOM_CORNERS = 1300;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = DEPTH + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [IB-1:0] pos;
		logic [IB-1:0] nrm;
		logic [IB:0]   tex;
	} corner_key_t;

	typedef struct packed {
		logic [VTX_BITS-1:0] vertex_index;
		logic                vertex_is_new;
		logic                triangle_valid;
		logic [VTX_BITS-1:0] tri_first;
		logic [VTX_BITS-1:0] tri_second;
		logic [VTX_BITS-1:0] tri_third;
		logic                table_full;
		logic                face_too_short;
		logic                corner_dropped;
	} vtx_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [IB-1:0]       position_index = '0;
	logic [IB-1:0]       normal_index = '0;
	logic signed [IB:0]  texture_index = '0;
	logic                last_corner = 1'b0;
	logic                start_mesh = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VTX_BITS-1:0] vertex_index;
	logic                vertex_is_new;
	logic                triangle_valid;
	logic [VTX_BITS-1:0] triangle_first;
	logic [VTX_BITS-1:0] triangle_second;
	logic [VTX_BITS-1:0] triangle_third;
	logic                table_full;
	logic                face_too_short;
	logic                corner_dropped;

	// model of the vertex table and the open face
	logic [IB-1:0] vt_pos [DEPTH];
	logic [IB-1:0] vt_nrm [DEPTH];
	logic [IB:0]   vt_tex [DEPTH];
	int            vt_used;
	int            face_corners;
	int            first_vtx;
	int            prev_vtx;

	vtx_result_t   expected_q [$];
	vtx_result_t   want_r;
	corner_key_t   key_pool [$];

	int mismatches;
	int corners_sent;
	int results_seen;
	int n_tri, n_new, n_full, n_short, n_drop, n_mesh;
	int burst_left;
	int hold_req;
	int hold_left;
	int rx_mode;
	int rx_seg_left;
	int idle_cycles;

	vertex_dedup_fan_triangulator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.position_index  (position_index),
		.normal_index    (normal_index),
		.texture_index   (texture_index),
		.last_corner     (last_corner),
		.start_mesh      (start_mesh),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.vertex_index    (vertex_index),
		.vertex_is_new   (vertex_is_new),
		.triangle_valid  (triangle_valid),
		.triangle_first  (triangle_first),
		.triangle_second (triangle_second),
		.triangle_third  (triangle_third),
		.table_full      (table_full),
		.face_too_short  (face_too_short),
		.corner_dropped  (corner_dropped)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic vtx_result_t resolve_corner(input corner_key_t k, input bit last,
			input bit start);
		vtx_result_t r;
		int          idx;
		bit          found;
		r = '0;
		idx = 0;
		found = 1'b0;
		if (start) begin
			vt_used = 0;
			face_corners = 0;
			first_vtx = 0;
			prev_vtx = 0;
		end
		if (face_corners >= FACE_LIMIT) begin
			r.corner_dropped = 1'b1;
		end else begin
			for (int i = 0; i < vt_used; i++) begin
				if (!found && vt_pos[i] == k.pos && vt_nrm[i] == k.nrm && vt_tex[i] == k.tex) begin
					idx = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (vt_used < DEPTH) begin
					vt_pos[vt_used] = k.pos;
					vt_nrm[vt_used] = k.nrm;
					vt_tex[vt_used] = k.tex;
					idx = vt_used;
					vt_used++;
					r.vertex_is_new = 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
			if (face_corners == 0) begin
				first_vtx = idx;
			end else if (face_corners >= TRI_START_CORNER) begin
				r.triangle_valid = 1'b1;
				r.tri_first = first_vtx[VTX_BITS-1:0];
				r.tri_second = prev_vtx[VTX_BITS-1:0];
				r.tri_third = idx[VTX_BITS-1:0];
			end
			prev_vtx = idx;
			face_corners++;
		end
		if (last) begin
			r.face_too_short = face_corners < MIN_FACE_CORNERS;
			face_corners = 0;
		end
		r.vertex_index = idx[VTX_BITS-1:0];
		return r;
	endfunction

	function automatic logic [IB:0] random_tex();
		logic [IB:0] t;
		t = (IB + 1)'($urandom_range(0, (1 << IB) - 1));
		if ($urandom_range(0, 3) == 0)
			t = '1;
		return t;
	endfunction

	function automatic corner_key_t random_key();
		corner_key_t k;
		k.pos = IB'($urandom_range(0, (1 << IB) - 1));
		k.nrm = IB'($urandom_range(0, (1 << IB) - 1));
		k.tex = random_tex();
		return k;
	endfunction

	function automatic corner_key_t make_key(input int p, input int n, input int t);
		corner_key_t k;
		k.pos = IB'(p);
		k.nrm = IB'(n);
		k.tex = (IB + 1)'(t);
		return k;
	endfunction

	// new pool of keys, many of them near misses of each other
	task automatic build_pool(input int count);
		corner_key_t k;
		key_pool.delete();
		for (int i = 0; i < count; i++) begin
			k = random_key();
			if (key_pool.size() != 0 && $urandom_range(0, 1) == 0) begin
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				case ($urandom_range(0, 2))
					0: k.pos = IB'($urandom_range(0, (1 << IB) - 1));
					1: k.nrm = k.nrm ^ IB'(1 << $urandom_range(0, IB - 1));
					default: k.tex = random_tex();
				endcase
			end
			key_pool.push_back(k);
		end
	endtask

	function automatic corner_key_t pool_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	task automatic send_corner(input corner_key_t k, input bit last, input bit start);
		int          gap;
		vtx_result_t pred;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid       <= 1'b1;
		position_index <= k.pos;
		normal_index   <= k.nrm;
		texture_index  <= k.tex;
		last_corner    <= last;
		start_mesh     <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = resolve_corner(k, last, start);
		expected_q.push_back(pred);
		corners_sent++;
		burst_left--;
		n_mesh  += int'(start);
		n_tri   += int'(pred.triangle_valid);
		n_new   += int'(pred.vertex_is_new);
		n_full  += int'(pred.table_full);
		n_short += int'(pred.face_too_short);
		n_drop  += int'(pred.corner_dropped);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch at result %0d: %s expected %0d got %0d",
					results_seen, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result item with no corner pending");
			end else begin
				want_r = expected_q.pop_front();
				check_field("vertex_index", want_r.vertex_index, vertex_index);
				check_field("vertex_is_new", 8'(want_r.vertex_is_new), 8'(vertex_is_new));
				check_field("triangle_valid", 8'(want_r.triangle_valid), 8'(triangle_valid));
				check_field("triangle_first", want_r.tri_first, triangle_first);
				check_field("triangle_second", want_r.tri_second, triangle_second);
				check_field("triangle_third", want_r.tri_third, triangle_third);
				check_field("table_full", 8'(want_r.table_full), 8'(table_full));
				check_field("face_too_short", 8'(want_r.face_too_short), 8'(face_too_short));
				check_field("corner_dropped", 8'(want_r.corner_dropped), 8'(corner_dropped));
			end
			results_seen++;
		end
	end

	// output stall pattern, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req > 0) begin
			hold_left = hold_req - 1;
			hold_req = 0;
			out_ready <= 1'b0;
		end else begin
			if (rx_seg_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_seg_left = $urandom_range(20, 200);
			end
			rx_seg_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 9) < 2);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (in_valid || expected_q.size() != 0)
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("[vertex_dedup_fan_triangulator] ERROR");
				$finish;
			end
		end
	end

	task automatic test_basic_faces();
		corner_key_t ka, kb, kc, kd, ke, kf;
		ka = make_key(0, 0, -1);
		kb = make_key((1 << IB) - 1, (1 << IB) - 1, (1 << IB) - 1);
		kc = make_key(0, 0, 0);
		kd = make_key(0, 0, (1 << IB) - 1);
		ke = make_key(1, 0, -1);
		kf = make_key(0, 1, -1);
		send_corner(ka, 1'b0, 1'b1);
		send_corner(kb, 1'b0, 1'b0);
		send_corner(kc, 1'b1, 1'b0);
		// pentagon with repeats and keys differing in one field
		send_corner(ka, 1'b0, 1'b0);
		send_corner(kc, 1'b0, 1'b0);
		send_corner(kd, 1'b0, 1'b0);
		send_corner(ke, 1'b0, 1'b0);
		send_corner(kf, 1'b1, 1'b0);
		// short faces
		send_corner(ka, 1'b1, 1'b0);
		send_corner(kb, 1'b0, 1'b0);
		send_corner(kc, 1'b1, 1'b0);
		// degenerate triangle
		send_corner(kb, 1'b0, 1'b0);
		send_corner(kb, 1'b0, 1'b0);
		send_corner(kb, 1'b1, 1'b0);
		// mesh restart inside an open face
		send_corner(ka, 1'b0, 1'b0);
		send_corner(kb, 1'b0, 1'b0);
		send_corner(ke, 1'b1, 1'b1);
		send_corner(kf, 1'b0, 1'b0);
		send_corner(ke, 1'b0, 1'b0);
		send_corner(kd, 1'b1, 1'b0);
	endtask

	task automatic test_corner_limit();
		build_pool(6);
		send_corner(pool_key(), 1'b0, 1'b1);
		for (int c = 1; c < FACE_LIMIT; c++)
			send_corner(pool_key(), c == FACE_LIMIT - 1, 1'b0);
		// face closed on a dropped corner
		for (int c = 0; c < FACE_LIMIT + 3; c++)
			send_corner(pool_key(), c == FACE_LIMIT + 2, 1'b0);
		for (int c = 0; c < FACE_LIMIT + 1; c++)
			send_corner(pool_key(), c == FACE_LIMIT, 1'b0);
		send_corner(pool_key(), 1'b0, 1'b0);
		send_corner(pool_key(), 1'b0, 1'b0);
		send_corner(pool_key(), 1'b1, 1'b0);
	endtask

	task automatic test_output_hold();
		build_pool(10);
		hold_req = HOLD_CYCLES;
		for (int c = 0; c < 16; c++)
			send_corner(pool_key(), c % 4 == 3, c == 0);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < DEPTH + 6; i++)
			send_corner(make_key(i, (1 << IB) - 1 - i, (i % 2) ? -1 : i), i % 4 == 3, i == 0);
		// hits on the first and last entries, misses on a full table
		send_corner(make_key(0, (1 << IB) - 1, 0), 1'b0, 1'b0);
		send_corner(make_key(DEPTH - 1, (1 << IB) - DEPTH, -1), 1'b0, 1'b0);
		send_corner(random_key(), 1'b0, 1'b0);
		send_corner(make_key(1, (1 << IB) - 2, -1), 1'b1, 1'b0);
		send_corner(random_key(), 1'b1, 1'b0);
		send_corner(random_key(), 1'b0, 1'b1);
		send_corner(random_key(), 1'b0, 1'b0);
		send_corner(random_key(), 1'b1, 1'b0);
	endtask

	task automatic test_random();
		int  target;
		int  len;
		int  pick;
		bit  fresh_mesh;
		corner_key_t k;
		target = corners_sent + RANDOM_CORNERS;
		fresh_mesh = 1'b1;
		while (corners_sent < target) begin
			if (fresh_mesh || $urandom_range(0, 14) == 0) begin
				build_pool($urandom_range(3, 40));
				fresh_mesh = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = $urandom_range(1, 2);
			else if (pick < 94)
				len = $urandom_range(3, 8);
			else if (pick < 98)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(FACE_LIMIT - 2, FACE_LIMIT + 4);
			for (int c = 0; c < len; c++) begin
				k = ($urandom_range(0, 9) == 0) ? random_key() : pool_key();
				send_corner(k, c == len - 1,
					(c == 0 && fresh_mesh) || (c > 0 && $urandom_range(0, 199) == 0));
			end
			fresh_mesh = 1'b0;
		end
	endtask

	initial begin
		vt_used = 0;
		face_corners = 0;
		first_vtx = 0;
		prev_vtx = 0;
		mismatches = 0;
		corners_sent = 0;
		results_seen = 0;
		n_tri = 0;
		n_new = 0;
		n_full = 0;
		n_short = 0;
		n_drop = 0;
		n_mesh = 0;
		burst_left = 0;
		hold_req = 0;
		hold_left = 0;
		rx_mode = 0;
		rx_seg_left = 0;
		idle_cycles = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_faces();
		test_corner_limit();
		test_output_hold();
		test_table_full();
		test_random();

		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d corners in %0d meshes: %0d triangles, %0d new vertices",
			corners_sent, n_mesh, n_tri, n_new);
		$display("%0d table-full misses, %0d short faces, %0d dropped corners, %0d mismatches",
			n_full, n_short, n_drop, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[vertex_dedup_fan_triangulator] OK");
		else
			$display("[vertex_dedup_fan_triangulator] ERROR");
		$finish;
	end

endmodule
